/* sv/elsm_pkg.sv */
// Shared types and constants for the event latency statistics monitor.
package elsm_pkg;

  localparam int unsigned NUM_PROBES_DEF = 64;

  localparam int unsigned CNT_W = 32;
  localparam int unsigned TOT_W = 48;
  localparam int unsigned DUR_W = 32;
  localparam int unsigned TS_W = 48;
  localparam int unsigned RATE_W = 46;
  localparam int unsigned MS_W = 29;

  // Shared divider widths: 48-bit dividend, 32-bit divisor
  localparam int unsigned DVD_W = 48;
  localparam int unsigned DVS_W = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [TOT_W-1:0] TOT_MAX = '1;
  localparam logic [DVS_W-1:0] NS_PER_MS = 32'd1000000;
  localparam logic [RATE_W-1:0] RATE_SCALE = 46'd10000;

  // Reciprocal of NS_PER_MS scaled by 2^TS_W, rounded down
  localparam int unsigned RCP_W = 29;
  localparam logic [RCP_W-1:0] MS_RECIP = 29'd281474976;

  typedef enum logic [2:0] {
    MODE_RECORD = 3'd0,
    MODE_START  = 3'd1,
    MODE_STOP   = 3'd2,
    MODE_CLEAR  = 3'd3,
    MODE_QUERY  = 3'd4
  } mode_t;

  typedef struct packed {
    logic [2:0]       mode;
    logic [7:0]       probe_id;
    logic [DUR_W-1:0] duration_ns;
    logic [TS_W-1:0]  now_ns;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [TOT_W-1:0] tot;
    logic [DUR_W-1:0] mx;
  } slot_t;

  typedef struct packed {
    slot_t           slot;
    logic [TS_W-1:0] elapsed;
    logic            sampling;
    logic            probe_valid;
  } snap_t;

  typedef struct packed {
    logic [CNT_W-1:0]  probe_count;
    logic [TOT_W-1:0]  sum_ns;
    logic [DUR_W-1:0]  max_ns;
    logic [DUR_W-1:0]  mean_ns;
    logic [RATE_W-1:0] rate_x10;
    logic [MS_W-1:0]   sampled_ms;
    logic              sampling_on;
    logic              probe_valid;
  } rsp_t;

endpackage

/* sv/elsm_if.sv */
// Request and response channel interfaces of the statistics monitor.
interface elsm_req_if import elsm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [2:0]       mode;
  logic [7:0]       probe_id;
  logic [DUR_W-1:0] duration_ns;
  logic [TS_W-1:0]  now_ns;

  modport source (output valid, mode, probe_id, duration_ns, now_ns, input ready);
  modport sink (input valid, mode, probe_id, duration_ns, now_ns, output ready);
endinterface

interface elsm_rsp_if import elsm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CNT_W-1:0]  probe_count;
  logic [TOT_W-1:0]  sum_ns;
  logic [DUR_W-1:0]  max_ns;
  logic [DUR_W-1:0]  mean_ns;
  logic [RATE_W-1:0] rate_x10;
  logic [MS_W-1:0]   sampled_ms;
  logic              sampling_on;
  logic              probe_valid;

  modport source (output valid, probe_count, sum_ns, max_ns, mean_ns, rate_x10,
                  sampled_ms, sampling_on, probe_valid, input ready);
  modport sink (input valid, probe_count, sum_ns, max_ns, mean_ns, rate_x10,
                sampled_ms, sampling_on, probe_valid, output ready);
endinterface

/* sv/elsm_div.sv */
// Restoring divider, one quotient bit per cycle, shared by the mean and rate divisions.
module elsm_div import elsm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int unsigned STEP_W = $clog2(DVD_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DVD_W - 1);

  logic              active;
  logic [STEP_W-1:0] steps;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [DVD_W-1:0]  q;
  logic [DVS_W:0]    rem_sh;
  logic [DVS_W+1:0]  diff;
  logic              fits;

  // Shift in the next dividend bit and trial-subtract the divisor
  assign rem_sh = {rem, q[DVD_W-1]};
  assign diff = {1'b0, rem_sh} - {2'b00, dvs};
  assign fits = !diff[DVS_W+1];
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && active && steps == LAST_STEP;
      if (start) begin
        active <= 1'b1;
      end else if (active && steps == LAST_STEP) begin
        active <= 1'b0;
      end
    end
    // Datapath holds no reset
    if (start) begin
      steps <= '0;
      rem <= '0;
      q <= dividend;
      dvs <= divisor;
    end else if (active) begin
      rem <= fits ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      q <= {q[DVD_W-2:0], fits};
      steps <= steps + STEP_W'(1);
    end
  end

endmodule

/* sv/elsm_stats.sv */
// Per-probe slot memory with read-modify-write, forwarding and window timekeeping.
module elsm_stats import elsm_pkg::*; #(
  parameter int unsigned NUM_PROBES = NUM_PROBES_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  accept,
  input  item_t item,
  output logic  query_pending,
  output snap_t snap
);

  localparam int unsigned AW = (NUM_PROBES > 1) ? $clog2(NUM_PROBES) : 1;

  slot_t                 mem [NUM_PROBES];
  slot_t                 rd_data;
  logic [NUM_PROBES-1:0] vbit;

  logic                  s1_valid;
  item_t                 s1_item;
  logic                  s1_in_range;
  logic [AW-1:0]         s1_idx;

  logic                  fwd_valid;
  logic [AW-1:0]         fwd_idx;
  slot_t                 fwd_data;

  logic                  sampling;
  logic [TS_W-1:0]       window_start;
  logic [TS_W-1:0]       banked;

  logic                  in_range;
  logic [AW-1:0]         idx;
  slot_t                 cur;
  slot_t                 upd;
  logic [TOT_W:0]        tot_sum;
  logic [TS_W-1:0]       win;
  logic [TS_W:0]         el_sum;
  logic [TS_W-1:0]       elapsed;
  logic                  do_write;
  logic                  do_clear;

  assign in_range = {1'b0, item.probe_id} < 9'(NUM_PROBES);
  assign idx = item.probe_id[AW-1:0];
  assign s1_idx = s1_item.probe_id[AW-1:0];

  // Pick the freshest copy of the entry: last write, then memory, else cleared
  always_comb begin
    cur = '0;
    if (fwd_valid && fwd_idx == s1_idx) begin
      cur = fwd_data;
    end else if (vbit[s1_idx]) begin
      cur = rd_data;
    end
  end

  // Saturating update for a record transaction
  always_comb begin
    tot_sum = {1'b0, cur.tot} + {{(TOT_W - DUR_W + 1){1'b0}}, s1_item.duration_ns};
    upd.cnt = (cur.cnt == CNT_MAX) ? cur.cnt : cur.cnt + CNT_W'(1);
    upd.tot = tot_sum[TOT_W] ? TOT_MAX : tot_sum[TOT_W-1:0];
    upd.mx = (s1_item.duration_ns > cur.mx) ? s1_item.duration_ns : cur.mx;
  end

  // Elapsed sampled time including the open window, saturating
  always_comb begin
    win = s1_item.now_ns - window_start;
    el_sum = {1'b0, banked} + {1'b0, win};
    if (sampling) begin
      elapsed = el_sum[TS_W] ? TOT_MAX : el_sum[TS_W-1:0];
    end else begin
      elapsed = banked;
    end
  end

  assign do_write = s1_valid && s1_in_range && s1_item.mode == MODE_RECORD;
  assign do_clear = s1_valid && (s1_item.mode == MODE_START || s1_item.mode == MODE_CLEAR);
  assign query_pending = s1_valid && s1_item.mode == MODE_QUERY;

  always_comb begin
    snap.slot = s1_in_range ? cur : '0;
    snap.elapsed = elapsed;
    snap.sampling = sampling;
    snap.probe_valid = s1_in_range;
  end

  // Slot memory: one read port, one write port, registered read data
  always_ff @(posedge clk) begin
    if (accept && in_range) begin
      rd_data <= mem[idx];
    end
    if (do_write) begin
      mem[s1_idx] <= upd;
    end
  end

  // Stage register, forwarding copy, valid bits and window state
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
      s1_in_range <= in_range;
    end
    fwd_idx <= s1_idx;
    fwd_data <= upd;
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_valid <= 1'b0;
      vbit <= '0;
      sampling <= 1'b0;
      window_start <= '0;
      banked <= '0;
    end else begin
      s1_valid <= accept;
      fwd_valid <= do_write;
      if (do_write) begin
        vbit[s1_idx] <= 1'b1;
      end
      if (do_clear) begin
        vbit <= '0;
      end
      if (s1_valid) begin
        case (s1_item.mode)
          MODE_START: begin
            sampling <= 1'b1;
            banked <= '0;
            window_start <= s1_item.now_ns;
          end
          MODE_STOP: begin
            if (sampling) begin
              banked <= elapsed;
              sampling <= 1'b0;
              window_start <= '0;
            end
          end
          MODE_CLEAR: begin
            banked <= '0;
            window_start <= sampling ? s1_item.now_ns : '0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

/* sv/event_latency_stats_monitor_core.sv */
// Top level of the event latency statistics monitor: query sequencer and response register.
//
//   channel  dir  payload                                              handshake
//   req      in   mode, probe_id, duration_ns, now_ns                  valid/ready
//   rsp      out  probe_count, sum_ns, max_ns, mean_ns, rate_x10,      valid/ready
//                 sampled_ms, sampling_on, probe_valid
//
// Record, start, stop and clear transactions are taken one per cycle unless a query
// holds req.ready low; a record is read from the slot memory in its accept cycle and
// written back the next. A query holds req.ready low until its result is loaded:
// snapshot, millisecond conversion by reciprocal multiply (multiply, estimate, remainder,
// fix-up), mean and rate on the shared 48-step divider, each skipped for a zero divisor.
// Reset clears the per-entry valid bits at once, so no clearing pass follows reset.
// A stalled response holds in its register; a following query waits for it.
module event_latency_stats_monitor_core import elsm_pkg::*; #(
  parameter int unsigned NUM_PROBES = NUM_PROBES_DEF
) (
  input logic      clk,
  input logic      rst,
  elsm_req_if.sink   req,
  elsm_rsp_if.source rsp
);

  localparam int unsigned HALF_W = TS_W / 2;
  localparam int unsigned MS_PROD_W = HALF_W + RCP_W;
  localparam int unsigned MS_SUM_W = TS_W + RCP_W;

  typedef enum logic [3:0] {
    Q_IDLE,
    Q_MS_MUL,
    Q_MS_EST,
    Q_MS_REM,
    Q_MS_FIX,
    Q_MUL,
    Q_MEAN,
    Q_RATE_ST,
    Q_RATE,
    Q_DONE
  } qstate_t;

  qstate_t            state;
  item_t              item;
  logic               accept;
  logic               query_pending;
  snap_t              snap;

  snap_t              q_snap;
  logic [MS_W-1:0]    q_ms;
  logic [RATE_W-1:0]  q_prod;
  logic [DUR_W-1:0]   q_mean;
  logic [RATE_W-1:0]  q_rate;

  logic [MS_PROD_W-1:0]   ms_prod_hi;
  logic [MS_PROD_W-1:0]   ms_prod_lo;
  logic [MS_SUM_W-1:0]    ms_sum;
  logic [MS_W-1:0]        ms_est;
  logic [MS_W+DVS_W-1:0]  ms_back;
  logic [TS_W-1:0]        ms_rem;

  logic               div_start;
  logic [DVD_W-1:0]   div_dvd;
  logic [DVS_W-1:0]   div_dvs;
  logic               div_done;
  logic [DVD_W-1:0]   div_quo;

  logic               rsp_valid;
  rsp_t               rsp_data;

  assign item = '{mode: req.mode, probe_id: req.probe_id,
                  duration_ns: req.duration_ns, now_ns: req.now_ns};
  assign req.ready = (state == Q_IDLE) && !query_pending;
  assign accept = req.valid && req.ready;

  elsm_stats #(.NUM_PROBES(NUM_PROBES)) u_stats (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .item          (item),
    .query_pending (query_pending),
    .snap          (snap)
  );

  elsm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Millisecond estimate from the two half products, and its remainder check
  assign ms_sum = {ms_prod_hi, {HALF_W{1'b0}}} + MS_SUM_W'(ms_prod_lo);
  assign ms_back = ms_est * NS_PER_MS;

  // Sequence the divisions of a query and hand the result to the response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Q_IDLE;
      div_start <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // Pulse the divider start as the mean and rate divisions begin
      div_start <= (state == Q_MUL && q_snap.slot.cnt != '0) ||
                   (state == Q_RATE_ST && q_ms != '0);
      // Release the response register once taken, unless a new result loads it
      if (rsp_valid && rsp.ready && state != Q_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        Q_IDLE: begin
          if (query_pending) begin
            q_snap <= snap;
            state <= Q_MS_MUL;
          end
        end
        Q_MS_MUL: begin
          ms_prod_hi <= q_snap.elapsed[TS_W-1:HALF_W] * MS_RECIP;
          ms_prod_lo <= q_snap.elapsed[HALF_W-1:0] * MS_RECIP;
          state <= Q_MS_EST;
        end
        Q_MS_EST: begin
          // Estimate is exact or one short
          ms_est <= ms_sum[MS_SUM_W-1:TS_W];
          state <= Q_MS_REM;
        end
        Q_MS_REM: begin
          ms_rem <= q_snap.elapsed - ms_back[TS_W-1:0];
          state <= Q_MS_FIX;
        end
        Q_MS_FIX: begin
          q_ms <= (ms_rem >= TS_W'(NS_PER_MS)) ? ms_est + MS_W'(1) : ms_est;
          state <= Q_MUL;
        end
        Q_MUL: begin
          q_prod <= RATE_W'(q_snap.slot.cnt) * RATE_SCALE;
          if (q_snap.slot.cnt != '0) begin
            div_dvd <= q_snap.slot.tot;
            div_dvs <= q_snap.slot.cnt;
            state <= Q_MEAN;
          end else begin
            q_mean <= '0;
            state <= Q_RATE_ST;
          end
        end
        Q_MEAN: begin
          if (div_done) begin
            q_mean <= div_quo[DUR_W-1:0];
            state <= Q_RATE_ST;
          end
        end
        Q_RATE_ST: begin
          if (q_ms != '0) begin
            div_dvd <= DVD_W'(q_prod);
            div_dvs <= DVS_W'(q_ms);
            state <= Q_RATE;
          end else begin
            q_rate <= '0;
            state <= Q_DONE;
          end
        end
        Q_RATE: begin
          if (div_done) begin
            q_rate <= div_quo[RATE_W-1:0];
            state <= Q_DONE;
          end
        end
        Q_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            rsp_data <= '{probe_count: q_snap.slot.cnt, sum_ns: q_snap.slot.tot,
                          max_ns: q_snap.slot.mx, mean_ns: q_mean, rate_x10: q_rate,
                          sampled_ms: q_ms, sampling_on: q_snap.sampling,
                          probe_valid: q_snap.probe_valid};
            state <= Q_IDLE;
          end
        end
        default: state <= Q_IDLE;
      endcase
    end
  end

  // Drive the response channel from its register
  assign rsp.valid = rsp_valid;
  assign rsp.probe_count = rsp_data.probe_count;
  assign rsp.sum_ns = rsp_data.sum_ns;
  assign rsp.max_ns = rsp_data.max_ns;
  assign rsp.mean_ns = rsp_data.mean_ns;
  assign rsp.rate_x10 = rsp_data.rate_x10;
  assign rsp.sampled_ms = rsp_data.sampled_ms;
  assign rsp.sampling_on = rsp_data.sampling_on;
  assign rsp.probe_valid = rsp_data.probe_valid;

endmodule

/* sim/elsm_stats_checker.sv */
// Checker for the statistics monitor: tracks probe state, predicts query responses, compares.
module elsm_stats_checker import elsm_pkg::*; #(
  parameter int unsigned NUM_PROBES = NUM_PROBES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  elsm_req_if        req,
  elsm_rsp_if        rsp,
  output int         fail_count,
  output int         pending_results
);

  localparam int unsigned REPORT_LIMIT = 10;
  localparam logic [63:0] MASK48 = 64'h0000_FFFF_FFFF_FFFF;

  // Shadow copy of the per-probe statistics and the sampling window
  logic [CNT_W-1:0] probe_cnt [NUM_PROBES];
  logic [TOT_W-1:0] probe_tot [NUM_PROBES];
  logic [DUR_W-1:0] probe_max [NUM_PROBES];
  logic [TS_W-1:0]  win_start;
  logic [TS_W-1:0]  banked_ns;
  logic             window_open;

  rsp_t expected_rsp_q[$];

  function automatic logic [TOT_W-1:0] add_sat48(logic [TOT_W-1:0] a, logic [TOT_W-1:0] b);
    logic [63:0] sum;
    sum = 64'(a) + 64'(b);
    return (sum > MASK48) ? TOT_MAX : sum[TOT_W-1:0];
  endfunction

  // Banked time plus the open window, if any
  function automatic logic [TS_W-1:0] sampled_ns(logic [TS_W-1:0] now);
    if (window_open) begin
      return add_sat48(banked_ns, now - win_start);
    end
    return banked_ns;
  endfunction

  task automatic clear_stats();
    for (int i = 0; i < NUM_PROBES; i++) begin
      probe_cnt[i] = '0;
      probe_tot[i] = '0;
      probe_max[i] = '0;
    end
  endtask

  function automatic rsp_t predict_query(logic [7:0] probe, logic [TS_W-1:0] now);
    rsp_t        r;
    logic [63:0] ms;
    logic [63:0] cnt;
    logic [63:0] tot;
    logic [63:0] rate;
    r    = '0;
    ms   = 64'(sampled_ns(now)) / 64'(NS_PER_MS);
    rate = '0;
    if (probe < NUM_PROBES) begin
      cnt = 64'(probe_cnt[probe]);
      tot = 64'(probe_tot[probe]);
      r.probe_count = cnt[CNT_W-1:0];
      r.sum_ns      = tot[TOT_W-1:0];
      r.max_ns      = probe_max[probe];
      if (cnt != 0) begin
        r.mean_ns = DUR_W'(tot / cnt);
      end
      if (ms != 0) begin
        rate = (cnt * 64'(RATE_SCALE)) / ms;
      end
      r.rate_x10    = rate[RATE_W-1:0];
      r.probe_valid = 1'b1;
    end
    r.sampled_ms  = ms[MS_W-1:0];
    r.sampling_on = window_open;
    return r;
  endfunction

  // Advance the shadow state by one accepted request transaction
  task automatic apply_request(logic [2:0] mode, logic [7:0] probe, logic [DUR_W-1:0] dur,
                               logic [TS_W-1:0] now);
    case (mode)
      MODE_RECORD: begin
        if (probe < NUM_PROBES) begin
          if (probe_cnt[probe] != CNT_MAX) begin
            probe_cnt[probe] = probe_cnt[probe] + 1'b1;
          end
          probe_tot[probe] = add_sat48(probe_tot[probe], TOT_W'(dur));
          if (dur > probe_max[probe]) begin
            probe_max[probe] = dur;
          end
        end
      end
      MODE_START: begin
        window_open = 1'b1;
        clear_stats();
        banked_ns = '0;
        win_start = now;
      end
      MODE_STOP: begin
        if (window_open) begin
          banked_ns   = sampled_ns(now);
          window_open = 1'b0;
          win_start   = '0;
        end
      end
      MODE_CLEAR: begin
        clear_stats();
        banked_ns = '0;
        win_start = window_open ? now : '0;
      end
      MODE_QUERY: begin
        expected_rsp_q.push_back(predict_query(probe, now));
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
        $display("mismatch on %s: expected %0h, got %0h", name, exp_v, act_v);
      end
    end
  endtask

  always @(posedge clk) begin
    rsp_t got;
    rsp_t want;
    if (rst) begin
      clear_stats();
      win_start   = '0;
      banked_ns   = '0;
      window_open = 1'b0;
      expected_rsp_q.delete();
    end else begin
      // Compare the response transaction first: it cannot belong to a query taken this edge
      if (rsp.valid && rsp.ready) begin
        got.probe_count = rsp.probe_count;
        got.sum_ns      = rsp.sum_ns;
        got.max_ns      = rsp.max_ns;
        got.mean_ns     = rsp.mean_ns;
        got.rate_x10    = rsp.rate_x10;
        got.sampled_ms  = rsp.sampled_ms;
        got.sampling_on = rsp.sampling_on;
        got.probe_valid = rsp.probe_valid;
        if (expected_rsp_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("unexpected response transaction, probe_count %0h", got.probe_count);
          end
        end else begin
          want = expected_rsp_q.pop_front();
          check_field("probe_count", 64'(want.probe_count), 64'(got.probe_count));
          check_field("sum_ns",      64'(want.sum_ns),      64'(got.sum_ns));
          check_field("max_ns",      64'(want.max_ns),      64'(got.max_ns));
          check_field("mean_ns",     64'(want.mean_ns),     64'(got.mean_ns));
          check_field("rate_x10",    64'(want.rate_x10),    64'(got.rate_x10));
          check_field("sampled_ms",  64'(want.sampled_ms),  64'(got.sampled_ms));
          check_field("sampling_on", 64'(want.sampling_on), 64'(got.sampling_on));
          check_field("probe_valid", 64'(want.probe_valid), 64'(got.probe_valid));
        end
      end
      if (req.valid && req.ready) begin
        apply_request(req.mode, req.probe_id, req.duration_ns, req.now_ns);
      end
    end
    pending_results <= expected_rsp_q.size();
  end

endmodule

/* sim/tb_event_latency_stats_monitor_core.sv */
// Testbench top for the statistics monitor: clock, reset, stimulus and verdict.
module tb_event_latency_stats_monitor_core;
  import elsm_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int unsigned TAIL_CYCLES  = 200;
  localparam int unsigned SEGMENTS     = 18;
  localparam int unsigned SEG_ITEMS    = 100;
  localparam logic [2:0]  MODE_UNUSED_FIRST = 3'd5;
  localparam logic [2:0]  MODE_UNUSED_LAST  = 3'd7;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending_results;
  int   cycle_count;
  bit   no_idle;

  elsm_req_if req_ch ();
  elsm_rsp_if rsp_ch ();

  event_latency_stats_monitor_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  elsm_stats_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .req             (req_ch),
    .rsp             (rsp_ch),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Response side: hold ready low for a random stall on each result, none when no_idle is set
  initial begin
    int gap;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rsp_ch.valid) @(posedge clk);
        repeat (gap - 1) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  // Present one request and hold it until the transaction completes; valid stays high after
  task automatic send_req(logic [2:0] mode, logic [7:0] probe, logic [DUR_W-1:0] dur,
                          logic [TS_W-1:0] now);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.mode        <= mode;
    req_ch.probe_id    <= probe;
    req_ch.duration_ns <= dur;
    req_ch.now_ns      <= now;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Hold off until every predicted response has been taken
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_probe();
    if ($urandom_range(0, 9) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    return 8'($urandom_range(0, NUM_PROBES_DEF - 1));
  endfunction

  function automatic logic [DUR_W-1:0] pick_duration();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1000);
      2: return $urandom_range(0, 1) ? '1 : '0;
      default: return $urandom_range(0, 5_000_000);
    endcase
  endfunction

  initial begin
    logic [TS_W-1:0] t_now;
    logic [2:0]      mode;
    int              sel;
    rst                <= 1'b1;
    no_idle            = 1'b0;
    req_ch.valid       <= 1'b0;
    req_ch.mode        <= MODE_RECORD;
    req_ch.probe_id    <= '0;
    req_ch.duration_ns <= '0;
    req_ch.now_ns      <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty state, field extremes, out-of-range probes
    send_req(MODE_QUERY,  8'd0,   '0,         48'd0);
    send_req(MODE_RECORD, 8'd0,   '0,         48'd100);
    send_req(MODE_RECORD, 8'd0,   '1,         48'd200);
    send_req(MODE_RECORD, 8'd63,  32'd12345,  48'd300);
    send_req(MODE_RECORD, 8'd64,  32'd7,      48'd400);
    send_req(MODE_RECORD, 8'd255, '1,         48'd500);
    send_req(MODE_QUERY,  8'd0,   '0,         48'd600);
    send_req(MODE_QUERY,  8'd63,  '0,         48'd650);
    send_req(MODE_QUERY,  8'd255, '0,         48'd700);
    // Stop while off, then a window that wraps the timestamp
    send_req(MODE_STOP,   8'd0,   '0,         48'd800);
    send_req(MODE_START,  8'd0,   '0,         48'hFFFF_FFF8_5EE0);
    send_req(MODE_RECORD, 8'd1,   32'd100,    48'hFFFF_FFFF_0000);
    send_req(MODE_QUERY,  8'd1,   '0,         48'hFFFF_FFFF_FFFF);
    send_req(MODE_QUERY,  8'd1,   '0,         48'd3_000_000);
    send_req(MODE_QUERY,  8'd2,   '0,         48'd3_100_000);
    // Clear while on restarts the window; stop banks it; clear while off
    send_req(MODE_CLEAR,  8'd0,   '0,         48'd4_000_000);
    send_req(MODE_RECORD, 8'd1,   32'd5,      48'd4_100_000);
    send_req(MODE_QUERY,  8'd1,   '0,         48'd10_000_000);
    send_req(MODE_STOP,   8'd0,   '0,         48'd12_000_000);
    send_req(MODE_QUERY,  8'd1,   '0,         48'd50_000_000);
    send_req(MODE_CLEAR,  8'd0,   '0,         48'd60_000_000);
    send_req(MODE_QUERY,  8'd1,   '0,         48'd61_000_000);
    // Unused modes leave everything alone
    for (logic [3:0] m = 4'(MODE_UNUSED_FIRST); m <= 4'(MODE_UNUSED_LAST); m++) begin
      send_req(m[2:0], 8'($urandom), $urandom, {16'($urandom), 32'($urandom)});
    end
    // Restart while on, then a very long window
    send_req(MODE_START,  8'd0,   '0,         48'd70_000_000);
    send_req(MODE_START,  8'd0,   '0,         48'd80_000_000);
    send_req(MODE_RECORD, 8'd63,  '1,         48'd81_000_000);
    send_req(MODE_QUERY,  8'd63,  '0,         48'h8000_0000_0000);
    drain_results();

    // Random: mostly records on a monotonic clock, with window commands and queries mixed in
    t_now = 48'h8000_0000_0000;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < SEG_ITEMS; n++) begin
        case ($urandom_range(0, 3))
          0: t_now = t_now + 48'($urandom_range(0, 1000));
          1: t_now = t_now + 48'($urandom_range(0, 2_000_000));
          2: t_now = t_now + 48'($urandom);
          default: t_now = t_now + 48'($urandom_range(0, 50));
        endcase
        if ($urandom_range(0, 99) == 0) begin
          t_now = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 5_000_000));
        end
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
          send_req(MODE_RECORD, pick_probe(), pick_duration(), t_now);
        end else if (sel < 82) begin
          send_req(MODE_QUERY, pick_probe(), pick_duration(), t_now);
        end else if (sel < 86) begin
          send_req(MODE_START, pick_probe(), pick_duration(), t_now);
        end else if (sel < 90) begin
          send_req(MODE_STOP, pick_probe(), pick_duration(), t_now);
        end else if (sel < 94) begin
          send_req(MODE_CLEAR, pick_probe(), pick_duration(), t_now);
        end else if (sel < 97) begin
          mode = 3'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
          send_req(mode, 8'($urandom), $urandom, t_now);
        end else begin
          // Noise: any mode with an arbitrary, non-monotonic timestamp
          mode = 3'($urandom_range(0, 7));
          send_req(mode, 8'($urandom), $urandom, {16'($urandom), 32'($urandom)});
        end
      end
      if (seg == SEGMENTS / 2) begin
        drain_results();
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
